// ===== design/lpbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbc_pkg
// Shared types, sizes and helpers for the latency percentile budget check.
// ----------------------------------------------------------------------------
package lpbc_pkg;

   // store geometry
   localparam int MAX_SAMPLES = 64;
   localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

   // field widths
   localparam int TIME_W = 32;
   localparam int MEM_W  = 48;
   localparam int CSR_W  = 48;

   // divide by 100 through a scaled reciprocal; exact for numerators below
   // 2**P95_SHIFT / (P95_RECIP * 100 - 2**P95_SHIFT)
   localparam int P95_SHIFT = 24;
   localparam int P95_RECIP = (2 ** P95_SHIFT + 99) / 100;
   localparam int P95_NUM_W = $clog2(95 * MAX_SAMPLES + 100);
   localparam int P95_REC_W = $clog2(P95_RECIP + 1);
   localparam int P95_PRD_W = P95_NUM_W + P95_REC_W;

   // register map
   typedef enum logic [1:0] {
      CSR_MEDIAN_LIMIT = 2'd0,
      CSR_P95_LIMIT    = 2'd1,
      CSR_MAXIMUM_LIMIT = 2'd2,
      CSR_MEMORY_LIMIT = 2'd3
   } csr_index_type;

   // request opcodes
   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_PASS   = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_TIMING = 2'd2,
      ST_MEMORY = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_SHIFT,
      S_INS_PUT,
      S_EV_MED,
      S_EV_P95,
      S_EV_MAX,
      S_EV_LAST
   } state_type;

   // index of the 95th percentile: ceil(95*n/100)-1, clamped to n-1 (n >= 1)
   function automatic logic [IDX_W-1:0] p95_index(input logic [CNT_W-1:0] n);
      logic [P95_NUM_W-1:0] num;
      logic [P95_PRD_W-1:0] prod;
      logic [CNT_W-1:0]     quot;
      logic [CNT_W-1:0]     idx;
      num  = P95_NUM_W'(95 * int'(n) + 99);
      prod = P95_PRD_W'(num) * P95_PRD_W'(P95_RECIP);
      quot = CNT_W'(prod >> P95_SHIFT);
      idx  = (quot == '0) ? '0 : quot - CNT_W'(1);
      if (idx > n - CNT_W'(1)) begin
         idx = n - CNT_W'(1);
      end
      return idx[IDX_W-1:0];
   endfunction

endpackage

// ===== design/latency_percentile_budget_check_core.sv =====
// ----------------------------------------------------------------------------
// latency_percentile_budget_check_core
// Sorted sample store with median / p95 / max pick and budget status check.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             beat
//  -------  ---  --------------------  ----------------------------------------
//  req      in   req_valid/req_stall   op, sample, used_bytes
//  rsp      out  rsp_valid/rsp_stall   status, median, percentile95, maximum,
//                                      overflowed (one beat per evaluate)
//  csr      in   csr_wr_en             csr_index, csr_wr_data
//
//  An add beat on a full store is dropped with no stall. On an empty store
//  req_stall stays high while S_INS_PUT writes the beat, else while S_INS_RD
//  and S_INS_SHIFT pass over the k stored samples larger than it (at most 63),
//  then S_INS_PUT if all k moved: one compare-and-move step per cycle through
//  the single store read port.
//  An evaluate beat holds req_stall through S_EV_MED to S_EV_LAST (three
//  store reads through the same port, one shared comparator), skips them
//  when the set is empty, and holds on while the output register is stalled.
//  req_stall is high while a beat is in work; a finished result may wait in
//  the output register while the next beat is accepted.
//  Reset is synchronous, clears counts and flags and sets limits to all ones;
//  the store itself is not cleared, only entries below the count are read.
//
module latency_percentile_budget_check_core (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [lpbc_pkg::TIME_W-1:0] req_sample,
   input  logic [lpbc_pkg::MEM_W-1:0]  req_used_bytes,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [lpbc_pkg::TIME_W-1:0] rsp_median,
   output logic [lpbc_pkg::TIME_W-1:0] rsp_percentile95,
   output logic [lpbc_pkg::TIME_W-1:0] rsp_maximum,
   output logic                        rsp_overflowed,
   // configuration port
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [lpbc_pkg::CSR_W-1:0]  csr_wr_data
);
   import lpbc_pkg::*;

   // sequencer and counters
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             fail_ff, fail_in;
   logic             empty_ff, empty_in;
   logic             done_ff, done_in;

   // working data
   logic [TIME_W-1:0] value_ff, value_in;
   logic [MEM_W-1:0]  used_ff, used_in;
   logic [TIME_W-1:0] med_ff, med_in;
   logic [TIME_W-1:0] p95_ff, p95_in;
   logic [TIME_W-1:0] max_ff, max_in;

   // limits
   logic [TIME_W-1:0] median_limit_ff;
   logic [TIME_W-1:0] p95_limit_ff;
   logic [TIME_W-1:0] maximum_limit_ff;
   logic [MEM_W-1:0]  memory_limit_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [TIME_W-1:0] rsp_med_ff, rsp_p95_ff, rsp_max_ff;
   logic              rsp_ovf_ff;

   // store and its ports
   logic [TIME_W-1:0] store_mem [MAX_SAMPLES];
   logic [TIME_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [TIME_W-1:0] wr_data;

   // shared comparator
   logic [MEM_W-1:0] cmp_a, cmp_b;
   logic             cmp_gt;

   logic req_take, rsp_take, out_free, full, load_rsp;

   assign req_stall = (state_ff != S_IDLE) || done_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign full      = (count_ff == CNT_W'(MAX_SAMPLES));
   assign load_rsp  = done_ff && out_free;
   assign cmp_gt    = cmp_a > cmp_b;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take && (req_op == OP_ADD) && !full) begin
               state_in = (count_ff == '0) ? S_INS_PUT : S_INS_RD;
            end else if (req_take && (req_op == OP_EVAL) && (count_ff != '0)) begin
               state_in = S_EV_MED;
            end
         end
         S_INS_RD:    state_in = S_INS_SHIFT;
         S_INS_SHIFT: begin
            if (!cmp_gt) begin
               state_in = S_IDLE;
            end else if (pos_ff == IDX_W'(1)) begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: state_in = S_IDLE;
         S_EV_MED:  state_in = S_EV_P95;
         S_EV_P95:  state_in = S_EV_MAX;
         S_EV_MAX:  state_in = S_EV_LAST;
         S_EV_LAST: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      pos_in     = pos_ff;
      fail_in    = fail_ff;
      empty_in   = empty_ff;
      done_in    = done_ff;
      value_in   = value_ff;
      used_in    = used_ff;
      med_in     = med_ff;
      p95_in     = p95_ff;
      max_in     = max_ff;
      rd_addr    = pos_ff - IDX_W'(1);
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = value_ff;
      cmp_a      = {{(MEM_W-TIME_W){1'b0}}, rd_data_ff};
      cmp_b      = {{(MEM_W-TIME_W){1'b0}}, value_ff};
      status_in  = status_ff;
      case (state_ff)
         S_IDLE: begin
            // take a beat: start an insert, drop on full, or start an evaluate
            if (req_take && (req_op == OP_ADD)) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  value_in = req_sample;
                  pos_in   = count_ff[IDX_W-1:0];
               end
            end else if (req_take) begin
               used_in  = req_used_bytes;
               fail_in  = 1'b0;
               empty_in = (count_ff == '0);
               done_in  = (count_ff == '0);
               med_in   = '0;
               p95_in   = '0;
               max_in   = '0;
            end
            // final budget check on the memory figure
            cmp_a = used_ff;
            cmp_b = memory_limit_ff;
            if (empty_ff) begin
               status_in = ST_EMPTY;
            end else if (fail_ff) begin
               status_in = ST_TIMING;
            end else if (cmp_gt) begin
               status_in = ST_MEMORY;
            end else begin
               status_in = ST_PASS;
            end
            if (load_rsp) begin
               done_in    = 1'b0;
               count_in   = '0;
               dropped_in = 1'b0;
            end
         end
         S_INS_SHIFT: begin
            // move the larger neighbor up, or settle the new value here
            rd_addr = pos_ff - IDX_W'(2);
            wr_en   = 1'b1;
            if (cmp_gt) begin
               wr_data = rd_data_ff;
               pos_in  = pos_ff - IDX_W'(1);
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         S_INS_PUT: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNT_W'(1);
         end
         S_EV_MED: begin
            rd_addr = count_ff[CNT_W-1:1];
         end
         S_EV_P95: begin
            rd_addr = p95_index(count_ff);
            med_in  = rd_data_ff;
            cmp_b   = {{(MEM_W-TIME_W){1'b0}}, median_limit_ff};
            fail_in = fail_ff || cmp_gt;
         end
         S_EV_MAX: begin
            rd_addr = IDX_W'(count_ff - CNT_W'(1));
            p95_in  = rd_data_ff;
            cmp_b   = {{(MEM_W-TIME_W){1'b0}}, p95_limit_ff};
            fail_in = fail_ff || cmp_gt;
         end
         S_EV_LAST: begin
            max_in  = rd_data_ff;
            cmp_b   = {{(MEM_W-TIME_W){1'b0}}, maximum_limit_ff};
            fail_in = fail_ff || cmp_gt;
            done_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         done_ff      <= 1'b0;
         empty_ff     <= 1'b0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         done_ff      <= done_in;
         empty_ff     <= empty_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working data registers
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      value_ff <= value_in;
      used_ff  <= used_in;
      med_ff   <= med_in;
      p95_ff   <= p95_in;
      max_ff   <= max_in;
   end

   // output payload, loaded with the finished result
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         status_ff  <= status_in;
         rsp_med_ff <= med_ff;
         rsp_p95_ff <= p95_ff;
         rsp_max_ff <= max_ff;
         rsp_ovf_ff <= dropped_ff;
      end
   end

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         median_limit_ff  <= '1;
         p95_limit_ff     <= '1;
         maximum_limit_ff <= '1;
         memory_limit_ff  <= '1;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MEDIAN_LIMIT:  median_limit_ff  <= csr_wr_data[TIME_W-1:0];
            CSR_P95_LIMIT:     p95_limit_ff     <= csr_wr_data[TIME_W-1:0];
            CSR_MAXIMUM_LIMIT: maximum_limit_ff <= csr_wr_data[TIME_W-1:0];
            CSR_MEMORY_LIMIT:  memory_limit_ff  <= csr_wr_data[MEM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sample store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_median       = rsp_med_ff;
   assign rsp_percentile95 = rsp_p95_ff;
   assign rsp_maximum      = rsp_max_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

`ifndef SYNTHESIS
   // the count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond store depth");

   // a fresh result leaves an empty set and a clear drop flag behind
   a_clear_after_eval: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (count_ff == '0) && !dropped_ff && rsp_valid_ff)
      else $error("set not cleared after evaluation");

   // an empty-set result carries zero statistics
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == ST_EMPTY)) |->
         (rsp_med_ff == '0) && (rsp_p95_ff == '0) && (rsp_max_ff == '0))
      else $error("empty result with nonzero statistics");

   // a waiting result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(status_ff))
      else $error("stalled result changed");
`endif

endmodule

// ===== tb/latency_percentile_budget_check_core_test.sv =====
// ----------------------------------------------------------------------------
// latency_percentile_budget_check_core_test
// Self-checking bench for the sorted sample store and the budget verdict.
// Add beats load timing samples into a local sorted copy of the store and
// evaluate beats turn that copy into an expected verdict. Every result beat
// is compared with the oldest expected verdict, field by field. Directed
// tests cover empty sets, ties, extremes, limit boundaries and store
// overflow. Random phases then walk through several limit settings; in all
// but the last, both handshake sides pause in random bursts.
// ----------------------------------------------------------------------------
module latency_percentile_budget_check_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lpbc_pkg::*;

   // an add beat may still shift the store after its acceptance
   localparam int SETTLE_CYCLES = MAX_SAMPLES + 16;

   typedef struct {
      op_type              op;
      logic [TIME_W-1:0]   sample;
      logic [MEM_W-1:0]    used_bytes;
   } budget_beat_type;

   typedef struct {
      status_type          status;
      logic [TIME_W-1:0]   median;
      logic [TIME_W-1:0]   percentile95;
      logic [TIME_W-1:0]   maximum;
      logic                overflowed;
   } budget_verdict_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic                req_op         = 1'b0;
   logic [TIME_W-1:0]   req_sample     = '0;
   logic [MEM_W-1:0]    req_used_bytes = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [1:0]          rsp_status;
   logic [TIME_W-1:0]   rsp_median;
   logic [TIME_W-1:0]   rsp_percentile95;
   logic [TIME_W-1:0]   rsp_maximum;
   logic                rsp_overflowed;
   logic                csr_wr_en      = 1'b0;
   logic [1:0]          csr_index      = '0;
   logic [CSR_W-1:0]    csr_wr_data    = '0;

   // local copy of the store, the flags and the limits
   logic [TIME_W-1:0]   latency_store[$];
   logic                samples_dropped = 1'b0;
   logic [TIME_W-1:0]   lim_median = '1;
   logic [TIME_W-1:0]   lim_p95    = '1;
   logic [TIME_W-1:0]   lim_max    = '1;
   logic [MEM_W-1:0]    lim_memory = '1;

   budget_verdict_type  pending_verdicts[$];
   budget_beat_type     req_beats[$];
   budget_beat_type     next_beat;
   bit                  beat_open   = 1'b0;
   int                  beats_queued = 0;
   int                  beats_taken  = 0;
   int                  gap_left     = 0;
   int                  stall_left   = 0;
   bit                  idling       = 1'b0;
   int                  error_count  = 0;

   latency_percentile_budget_check_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_sample       (req_sample),
      .req_used_bytes   (req_used_bytes),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_median       (rsp_median),
      .rsp_percentile95 (rsp_percentile95),
      .rsp_maximum      (rsp_maximum),
      .rsp_overflowed   (rsp_overflowed),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // place a sample after any equal ones; drop it when the store is full
   function automatic void store_sample(logic [TIME_W-1:0] value);
      int pos;
      if (latency_store.size() >= MAX_SAMPLES) begin
         samples_dropped = 1'b1;
         return;
      end
      pos = latency_store.size();
      while (pos > 0 && latency_store[pos-1] > value) pos--;
      latency_store.insert(pos, value);
   endfunction

   // pick median, p95 and maximum, judge them against the limits, empty the set
   function automatic budget_verdict_type judge_set(logic [MEM_W-1:0] used);
      budget_verdict_type v;
      int                 n;
      int                 p_idx;
      n = latency_store.size();
      v.overflowed = samples_dropped;
      if (n == 0) begin
         v.status       = ST_EMPTY;
         v.median       = '0;
         v.percentile95 = '0;
         v.maximum      = '0;
      end else begin
         p_idx = (95 * n + 99) / 100;
         if (p_idx > 0) p_idx--;
         if (p_idx > n - 1) p_idx = n - 1;
         v.median       = latency_store[n / 2];
         v.percentile95 = latency_store[p_idx];
         v.maximum      = latency_store[n - 1];
         if (v.median > lim_median || v.percentile95 > lim_p95 || v.maximum > lim_max)
            v.status = ST_TIMING;
         else if (used > lim_memory)
            v.status = ST_MEMORY;
         else
            v.status = ST_PASS;
      end
      latency_store.delete();
      samples_dropped = 1'b0;
      return v;
   endfunction

   function automatic void check_field(string field, logic [TIME_W-1:0] want,
                                       logic [TIME_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endfunction

   // drive request beats at the falling edge, with random gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (!beat_open && req_beats.size() != 0) begin
            if (idling && $urandom_range(0, 3) == 0) begin
               gap_left = $urandom_range(0, 13);
               req_valid <= 1'b0;
            end else begin
               next_beat = req_beats.pop_front();
               req_op         <= next_beat.op;
               req_sample     <= next_beat.sample;
               req_used_bytes <= next_beat.used_bytes;
               req_valid      <= 1'b1;
               beat_open = 1'b1;
            end
         end else if (!beat_open) begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall the result channel in random bursts
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left--;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // check result beats, then predict from accepted request beats
   always @(posedge clock) begin : watch_beats
      budget_verdict_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               error_count++;
               $display("%0t: result beat with none pending, expected none, actual status %h",
                        $time, rsp_status);
            end else begin
               want = pending_verdicts.pop_front();
               check_field("status", TIME_W'(want.status), TIME_W'(rsp_status));
               check_field("median", want.median, rsp_median);
               check_field("percentile95", want.percentile95, rsp_percentile95);
               check_field("maximum", want.maximum, rsp_maximum);
               check_field("overflowed", TIME_W'(want.overflowed), TIME_W'(rsp_overflowed));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_EVAL)
               pending_verdicts.push_back(judge_set(req_used_bytes));
            else
               store_sample(req_sample);
            beat_open = 1'b0;
            beats_taken++;
         end
      end
   end

   // queue one request beat and hold until it is accepted
   task automatic send_item(op_type op, logic [TIME_W-1:0] sample,
                            logic [MEM_W-1:0] used);
      int ticket;
      beats_queued++;
      ticket = beats_queued;
      req_beats.push_back('{op, sample, used});
      wait (beats_taken >= ticket);
   endtask

   // hold the sender until every verdict is back and the store is quiet
   task automatic drain_results();
      wait (req_beats.size() == 0 && !beat_open);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      case (idx)
         CSR_MEDIAN_LIMIT:  lim_median = data[TIME_W-1:0];
         CSR_P95_LIMIT:     lim_p95    = data[TIME_W-1:0];
         CSR_MAXIMUM_LIMIT: lim_max    = data[TIME_W-1:0];
         CSR_MEMORY_LIMIT:  lim_memory = data[MEM_W-1:0];
         default: ;
      endcase
   endtask

   // write all four limits while idle; upper bits of the time limits get junk
   task automatic set_limits(logic [TIME_W-1:0] med, logic [TIME_W-1:0] p95,
                             logic [TIME_W-1:0] mx, logic [MEM_W-1:0] mem);
      drain_results();
      write_csr(CSR_MEDIAN_LIMIT, {16'($urandom()), med});
      write_csr(CSR_P95_LIMIT, {16'($urandom()), p95});
      write_csr(CSR_MAXIMUM_LIMIT, {16'($urandom()), mx});
      write_csr(CSR_MEMORY_LIMIT, mem);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [MEM_W-1:0] rand_bytes();
      return MEM_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [TIME_W-1:0] pick_time(int mode, logic [TIME_W-1:0] center);
      case (mode)
         0:       return $urandom();
         1:       return center + TIME_W'($urandom_range(0, 6)) - TIME_W'(3);
         2:       return TIME_W'($urandom_range(0, 7));
         default: return ~TIME_W'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [MEM_W-1:0] pick_bytes(logic [MEM_W-1:0] center);
      if ($urandom_range(0, 1) == 0)
         return rand_bytes();
      return center + MEM_W'($urandom_range(0, 4)) - MEM_W'(2);
   endfunction

   // evaluate with nothing loaded
   task automatic test_empty_set();
      send_item(OP_EVAL, '1, '1);
      send_item(OP_EVAL, '0, '0);
   endtask

   // extremes, ties and reverse order under the reset limits
   task automatic test_order_statistics();
      send_item(OP_ADD, '0, '1);
      send_item(OP_ADD, '1, '0);
      send_item(OP_EVAL, '0, '1);
      send_item(OP_ADD, 32'd7, '0);
      send_item(OP_ADD, 32'd3, '0);
      send_item(OP_ADD, 32'd7, '0);
      send_item(OP_ADD, 32'd3, '0);
      send_item(OP_ADD, 32'd7, '0);
      send_item(OP_EVAL, '0, '0);
      send_item(OP_ADD, 32'd9, '0);
      send_item(OP_ADD, 32'd8, '0);
      send_item(OP_ADD, 32'd6, '0);
      send_item(OP_EVAL, '0, 48'd12);
   endtask

   // fill past capacity in worst-case order, then exactly to capacity
   task automatic test_store_overflow();
      for (int i = 0; i < MAX_SAMPLES + 3; i++)
         send_item(OP_ADD, TIME_W'(1000 - i), rand_bytes());
      send_item(OP_EVAL, $urandom(), rand_bytes());
      for (int i = 0; i < MAX_SAMPLES; i++)
         send_item(OP_ADD, $urandom(), rand_bytes());
      send_item(OP_EVAL, $urandom(), rand_bytes());
      send_item(OP_EVAL, $urandom(), rand_bytes());
   endtask

   // strict comparisons, timing before memory, zero limits
   task automatic test_limit_boundaries();
      set_limits(32'd100, 32'd200, 32'd300, 48'd1000);
      send_item(OP_ADD, 32'd100, '0);
      send_item(OP_EVAL, '0, 48'd1000);
      send_item(OP_ADD, 32'd101, '0);
      send_item(OP_EVAL, '0, 48'd0);
      send_item(OP_ADD, 32'd100, '0);
      send_item(OP_EVAL, '0, 48'd1001);
      send_item(OP_ADD, 32'd10, '0);
      send_item(OP_ADD, 32'd250, '0);
      send_item(OP_ADD, 32'd20, '0);
      send_item(OP_EVAL, '0, 48'd0);
      send_item(OP_ADD, 32'd500, '0);
      send_item(OP_EVAL, '0, 48'd5000);
      set_limits(32'd100, 32'd200, 32'd50, 48'd1000);
      send_item(OP_ADD, 32'd60, '0);
      send_item(OP_EVAL, '0, 48'd0);
      send_item(OP_ADD, 32'd50, '0);
      send_item(OP_EVAL, '0, 48'd1000);
      set_limits('0, '0, '0, '0);
      send_item(OP_ADD, '0, '1);
      send_item(OP_EVAL, '1, '0);
      send_item(OP_ADD, '0, '0);
      send_item(OP_EVAL, '0, 48'd1);
   endtask

   // random sets, mostly small, with samples clustered near the limits
   task automatic run_sets(int item_goal, logic [TIME_W-1:0] center,
                           logic [MEM_W-1:0] mem_center);
      int done;
      int count;
      int mode;
      int roll;
      done = 0;
      while (done < item_goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 12)      count = 0;
         else if (roll < 86) count = $urandom_range(1, 12);
         else if (roll < 96) count = $urandom_range(13, 63);
         else                count = $urandom_range(MAX_SAMPLES, MAX_SAMPLES + 6);
         mode = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(0, 3);
         repeat (count) send_item(OP_ADD, pick_time(mode, center), rand_bytes());
         send_item(OP_EVAL, $urandom(), pick_bytes(mem_center));
         done += count + 1;
         // now and then let every verdict come back before going on
         if ($urandom_range(0, 19) == 0) drain_results();
      end
   endtask

   task automatic test_random_budgets();
      logic [TIME_W-1:0] c;
      logic [MEM_W-1:0]  m;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               c = $urandom();
               m = rand_bytes();
               set_limits('1, '1, '1, '1);
            end
            1: begin
               c = '0;
               m = '0;
               set_limits('0, '0, '0, '0);
            end
            5: begin
               c = TIME_W'($urandom_range(0, 7));
               m = rand_bytes();
               set_limits(c, c + 1, c + 2, m);
               // last phase runs with no gaps and no stalls
               idling = 1'b0;
            end
            default: begin
               c = $urandom();
               m = rand_bytes();
               set_limits(c, c + 2, c + 4, m);
            end
         endcase
         run_sets(105, c, m);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idling = 1'b1;
      test_empty_set();
      test_order_statistics();
      test_store_overflow();
      test_limit_boundaries();
      test_random_budgets();
      drain_results();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // bound the run
   initial begin
      #(10_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
